// File: rtl/core/dbpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpc_pkg
// Shared types and codes for the delimited byte packet collector.
// ----------------------------------------------------------------------------
package dbpc_pkg;

    // register indexes on the configuration port
    localparam logic [7:0] REG_START   = 8'd0;
    localparam logic [7:0] REG_FINISH  = 8'd1;
    localparam logic [7:0] REG_LENGTH  = 8'd2;
    localparam logic [7:0] REG_TIMEOUT = 8'd3;

    // result kinds
    localparam logic [1:0] KIND_PKT = 2'd0;
    localparam logic [1:0] KIND_BAD = 2'd1;
    localparam logic [1:0] KIND_OVF = 2'd2;
    localparam logic [1:0] KIND_TMO = 2'd3;

    // input commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // width of a packet byte count or store address on the internal links
    localparam int CNT_W = 6;

    // command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  finish_byte;
        logic [5:0]  pkt_len;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // work for the emitter: a status word or a packet of count bytes
    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] count;
    } t_cmd;

    // store write from the classifier
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

endpackage : dbpc_pkg
`default_nettype wire

// File: rtl/core/dbpc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpc_queue
// Two-entry command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module dbpc_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  dbpc_pkg::t_cmd    i_push_cmd,
    input  wire               i_pop,
    output logic              o_valid,
    output dbpc_pkg::t_cmd    o_head,
    output logic              o_full,
    output logic [dbpc_pkg::QCNT_W-1:0] o_count
);
    import dbpc_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_cnt != QCNT_W'(QDEPTH));
    assign do_pop  = i_pop && (r_cnt != '0);

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    // hold the payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_count = r_cnt;

endmodule : dbpc_queue
`default_nettype wire

// File: rtl/core/dbpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpc_front
// Classifier: takes bytes and ticks, tracks collection, writes the store
// and queues packet or status work for the emitter.
// ----------------------------------------------------------------------------
module dbpc_front #(
    parameter int MAX_LEN = 32,
    parameter int FW      = $clog2(MAX_LEN + 1)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dbpc_pkg::t_cfg   i_cfg,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire              i_cmd,
    input  wire  [7:0]       i_rx_byte,
    output logic             o_push,
    output dbpc_pkg::t_cmd   o_push_cmd,
    input  wire              i_q_full,
    input  wire              i_pkt_done,
    output dbpc_pkg::t_wr    o_wr,
    output logic             o_busy
);
    import dbpc_pkg::*;

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          r_coll;
    logic          n_coll;
    logic [15:0]   r_tick;
    logic [15:0]   n_tick;
    logic [7:0]    r_first;
    logic [7:0]    n_first;
    logic          r_busy;

    logic          accept;
    logic [15:0]   tick_inc;
    logic          disabled;
    logic [5:0]    len;
    logic [FW-1:0] fill_inc;
    logic [7:0]    first_now;
    logic          push_pkt;

    assign o_in_stall = r_busy || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_busy     = r_busy;

    assign tick_inc = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;
    assign disabled = (i_cfg.start_byte == 8'd0) && (i_cfg.finish_byte == 8'd0)
                      && (i_cfg.pkt_len == 6'd0);
    assign len      = (i_cfg.pkt_len > 6'(MAX_LEN)) ? 6'(MAX_LEN)
                      : i_cfg.pkt_len;
    assign fill_inc = (r_fill < FW'(MAX_LEN)) ? r_fill + FW'(1) : r_fill;
    assign first_now = (r_fill == '0) ? i_rx_byte : r_first;

    // classify the word and work out the next collection state
    always_comb begin
        n_fill     = r_fill;
        n_coll     = r_coll;
        n_tick     = r_tick;
        n_first    = r_first;
        o_push     = 1'b0;
        o_push_cmd = '{kind: KIND_PKT, count: '0};
        o_wr       = '{we: 1'b0, addr: CNT_W'(r_fill), data: i_rx_byte};
        push_pkt   = 1'b0;
        if (accept) begin
            if (i_cmd == CMD_TICK) begin
                if (tick_inc >= i_cfg.timeout_ticks) begin
                    n_fill = '0;
                    n_coll = 1'b0;
                    n_tick = '0;
                    if (r_coll) begin
                        o_push     = 1'b1;
                        o_push_cmd = '{kind: KIND_TMO, count: '0};
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end else if (!disabled && (r_coll || (i_rx_byte == i_cfg.start_byte))) begin
                n_coll  = 1'b1;
                n_fill  = fill_inc;
                n_first = first_now;
                o_wr.we = (r_fill < FW'(MAX_LEN));
                if (len != 6'd0) begin
                    // fixed length: end at the length, check the header byte
                    if (6'(fill_inc) >= len) begin
                        n_fill = '0;
                        n_coll = 1'b0;
                        n_tick = '0;
                        o_push = 1'b1;
                        if (first_now == i_cfg.start_byte) begin
                            push_pkt   = 1'b1;
                            o_push_cmd = '{kind: KIND_PKT, count: CNT_W'(fill_inc)};
                        end else begin
                            o_push_cmd = '{kind: KIND_BAD, count: '0};
                        end
                    end
                end else if (i_rx_byte == i_cfg.finish_byte) begin
                    n_fill     = '0;
                    n_coll     = 1'b0;
                    n_tick     = '0;
                    o_push     = 1'b1;
                    push_pkt   = 1'b1;
                    o_push_cmd = '{kind: KIND_PKT, count: CNT_W'(fill_inc)};
                end else if (fill_inc >= FW'(MAX_LEN)) begin
                    n_fill     = '0;
                    n_coll     = 1'b0;
                    n_tick     = '0;
                    o_push     = 1'b1;
                    o_push_cmd = '{kind: KIND_OVF, count: '0};
                end
            end
        end
    end

    // update collection state; hold off input while a packet is in emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_coll <= 1'b0;
            r_tick <= '0;
            r_busy <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_coll <= n_coll;
            r_tick <= n_tick;
            if (push_pkt) begin
                r_busy <= 1'b1;
            end else if (i_pkt_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
    end

endmodule : dbpc_front
`default_nettype wire

// File: rtl/core/dbpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpc_back
// Emitter: holds the packet store and plays queued work out as result words
// through an output register.
// ----------------------------------------------------------------------------
module dbpc_back #(
    parameter int MAX_LEN = 32,
    parameter int FW      = $clog2(MAX_LEN + 1),
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  dbpc_pkg::t_wr    i_wr,
    input  wire              i_q_valid,
    input  dbpc_pkg::t_cmd   i_q_head,
    output logic             o_pop,
    output logic             o_pkt_done,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic             o_last
);
    import dbpc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SEND  = 2'd2;

    logic [7:0]    r_mem [MAX_LEN];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic [FW-1:0] r_count;
    logic [FW-1:0] n_count;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [1:0]    r_kind;
    logic          r_last;

    logic          out_free;
    logic          is_last;
    logic          load;
    logic [7:0]    ld_byte;
    logic [1:0]    ld_kind;
    logic          ld_last;

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = ((FW'(r_idx) + FW'(1)) == r_count);

    // sequence the queued work
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        rd_addr    = r_idx;
        o_pop      = 1'b0;
        o_pkt_done = 1'b0;
        load       = 1'b0;
        ld_byte    = 8'd0;
        ld_kind    = i_q_head.kind;
        ld_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_head.kind == KIND_PKT) begin
                        o_pop   = 1'b1;
                        n_idx   = '0;
                        n_count = i_q_head.count[FW-1:0];
                        n_state = S_FETCH;
                    end else if (out_free) begin
                        o_pop = 1'b1;
                        load  = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = r_rd_data;
                    ld_kind = KIND_PKT;
                    ld_last = is_last;
                    if (is_last) begin
                        o_pkt_done = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        rd_addr = n_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_count <= n_count;
        if (load) begin
            r_out_byte <= ld_byte;
            r_kind     <= ld_kind;
            r_last     <= ld_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_kind      = r_kind;
    assign o_last      = r_last;

endmodule : dbpc_back
`default_nettype wire

// File: rtl/core/delimited_byte_packet_collector.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a byte or tick is taken when not stalled; a status word goes through the queue and
// the output register, a packet byte through the queue, the store read and the output register.
// Throughput: one input word per cycle while collecting, unless the queue is full; a finished
// packet is played out at one byte per cycle from the store read port unless the output stalls, input held off.
// Reset: synchronous, active low; clears collection, fill and tick counters, the queue
// and the output; configuration returns to its reset values, the store is not cleared.
// ----------------------------------------------------------------------------
// delimited_byte_packet_collector
// Start-delimited byte packet collector with fixed-length and finish-byte
// framing, timeout drop and overflow reporting.
// ----------------------------------------------------------------------------
module delimited_byte_packet_collector #(
    parameter int MAX_LEN = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_index,
    input  wire [15:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_cmd,
    input  wire  [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);
    import dbpc_pkg::*;

    localparam int FW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    t_cfg              r_cfg;
    t_cmd              push_cmd;
    t_cmd              q_head;
    t_wr               wr;
    logic              push;
    logic              pop;
    logic              q_valid;
    logic              q_full;
    logic [QCNT_W-1:0] q_count;
    logic              pkt_done;
    logic              front_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= 8'd0;
            r_cfg.finish_byte   <= 8'd0;
            r_cfg.pkt_len       <= 6'd0;
            r_cfg.timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START:   r_cfg.start_byte    <= i_cfg_data[7:0];
                REG_FINISH:  r_cfg.finish_byte   <= i_cfg_data[7:0];
                REG_LENGTH:  r_cfg.pkt_len       <= i_cfg_data[5:0];
                REG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dbpc_front #(
        .MAX_LEN (MAX_LEN),
        .FW      (FW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_push_cmd (push_cmd),
        .i_q_full   (q_full),
        .i_pkt_done (pkt_done),
        .o_wr       (wr),
        .o_busy     (front_busy)
    );

    dbpc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .o_full     (q_full),
        .o_count    (q_count)
    );

    dbpc_back #(
        .MAX_LEN (MAX_LEN),
        .FW      (FW),
        .AW      (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_pkt_done  (pkt_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // a status word is always a single last word with a zero byte
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != KIND_PKT)) |-> (o_last && (o_out_byte == 8'd0)))
        else $error("status word without last or with nonzero byte");

    // input must be held off while a packet is being played out of the store
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_busy |-> o_in_stall)
        else $error("input taken while packet emission in progress");

    // the queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("command queue overfilled");

    // a push never meets a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into full queue");
`endif

endmodule : delimited_byte_packet_collector
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delimited byte packet collector. A directed
// table covers disabled mode, timeouts, bad headers, overflow and the length
// and byte extremes. Random framed traffic then runs under several register
// settings and idle/stall mixes. Every output word is checked against the
// table's own expectation or an in-bench framing predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import dbpc_pkg::*;

    localparam int     MAX_LEN   = 32;
    localparam int     CLK_HALF  = 10;
    localparam int     SETTLE    = MAX_LEN + 8;
    localparam longint LIMIT_NS  = 64'd10_000_000;
    localparam logic [7:0] REG_SPARE = 8'd7;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_out_word;

    // one word for the input channel; typed words carry their own expectation
    typedef struct packed {
        logic      cmd;
        logic [7:0] data;
        logic      typed;
        logic      t_n;
        t_out_word t_word;
    } t_in_word;

    typedef enum logic {ROW_CFG, ROW_WORD} t_row_op;

    typedef struct packed {
        t_row_op    op;
        logic [7:0] idx;
        logic [15:0] val;
        logic       cmd;
        logic [7:0] data;
        logic [5:0] reps;
        logic       typed;
        logic       t_n;
        t_out_word  t_word;
    } t_stim_row;

    localparam t_out_word NO_WORD  = '0;
    localparam t_out_word TMO_WORD = '{8'h00, KIND_TMO, 1'b1};
    localparam t_out_word BAD_WORD = '{8'h00, KIND_BAD, 1'b1};
    localparam t_out_word OVF_WORD = '{8'h00, KIND_OVF, 1'b1};
    localparam t_out_word ONE_5A   = '{8'h5A, KIND_PKT, 1'b1};

    localparam int NROWS = 35;
    localparam t_stim_row DIRECTED [NROWS] = '{
        // disabled after reset: bytes ignored, ticks only count
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h00, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'hFF, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_TICK, 8'h00, 6'd1, 1'b1, 1'b0, NO_WORD},
        // zero timeout, fixed length of three
        '{ROW_CFG,  REG_TIMEOUT, 16'h0000, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_START,   16'hA5FF, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_LENGTH,  16'h0003, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        // timeout while idle, stray byte, timeout while collecting
        '{ROW_WORD, 8'h00, 16'h0000, CMD_TICK, 8'h00, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h00, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'hFF, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_TICK, 8'h00, 6'd1, 1'b1, 1'b1, TMO_WORD},
        '{ROW_CFG,  REG_TIMEOUT, 16'hFFFF, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        // good fixed-length packet
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'hFF, 6'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h00, 6'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'hFF, 6'd1, 1'b0, 1'b0, NO_WORD},
        // start byte changed under a partial packet gives a bad header
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'hFF, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_START,   16'h0001, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h22, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h33, 6'd1, 1'b1, 1'b1, BAD_WORD},
        // length above the store size is clipped to a full store
        '{ROW_CFG,  REG_LENGTH,  16'h003F, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h01, 6'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'hA5, 6'd31, 1'b0, 1'b0, NO_WORD},
        // finish mode with start equal to finish: one-byte packet
        '{ROW_CFG,  REG_LENGTH,  16'h0000, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_START,   16'h005A, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_FINISH,  16'h005A, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h5A, 6'd1, 1'b1, 1'b1, ONE_5A},
        // repeated start keeps what is stored
        '{ROW_CFG,  REG_FINISH,  16'h000D, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h5A, 6'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h5A, 6'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h0D, 6'd1, 1'b0, 1'b0, NO_WORD},
        // full store without a finish byte overflows
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h5A, 6'd1, 1'b1, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h11, 6'd31, 1'b1, 1'b1, OVF_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h0D, 6'd1, 1'b1, 1'b0, NO_WORD},
        // write to an unused index must change nothing
        '{ROW_CFG,  REG_SPARE,   16'hFFFF, CMD_BYTE, 8'h00, 6'd0, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h5A, 6'd1, 1'b0, 1'b0, NO_WORD},
        '{ROW_WORD, 8'h00, 16'h0000, CMD_BYTE, 8'h0D, 6'd1, 1'b0, 1'b0, NO_WORD}
    };

    localparam int IDLE_PCT  [4] = '{0, 72, 0, 33};
    localparam int STALL_PCT [4] = '{0, 0, 72, 33};

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_index = 8'h00;
    logic [15:0] i_cfg_data  = 16'h0000;
    logic        i_in_valid  = 1'b0;
    logic        i_cmd       = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_stall = 1'b0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [7:0]  o_out_byte;
    wire  [1:0]  o_kind;
    wire         o_last;

    // framing predictor state and its copy of the registers
    logic [7:0]  cfg_start   = 8'h00;
    logic [7:0]  cfg_finish  = 8'h00;
    logic [5:0]  cfg_len     = 6'd0;
    logic [15:0] cfg_timeout = TIMEOUT_RESET;
    logic [7:0]  pkt_store [MAX_LEN];
    int          fill_cnt    = 0;
    logic        collecting  = 1'b0;
    logic [15:0] tick_cnt    = 16'h0000;

    t_in_word  word_q [$];
    t_out_word framed [$];
    t_out_word packet_words_due [$];
    t_in_word  cur_word;
    logic      in_flight = 1'b0;
    int        idle_pct  = 0;
    int        stall_pct = 0;
    int        n_words   = 0;
    int        n_pkt_bytes = 0;
    int        n_status  = 0;
    int        n_err     = 0;

    delimited_byte_packet_collector #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

    // drop the partial packet and restart the tick count
    function void drop_packet();
        fill_cnt   = 0;
        collecting = 1'b0;
        tick_cnt   = 16'h0000;
    endfunction

    function void emit_packet();
        t_out_word w;
        for (int k = 0; k < fill_cnt; k++) begin
            w = '{pkt_store[k], KIND_PKT, (k == fill_cnt - 1)};
            framed.insert(framed.size(), w);
        end
        drop_packet();
    endfunction

    // work out the output words caused by one input word
    function void frame_word(input logic cmd, input logic [7:0] b);
        int len_eff;
        framed.delete();
        len_eff = (cfg_len > MAX_LEN) ? MAX_LEN : int'(cfg_len);
        if (cmd == CMD_TICK) begin
            if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= cfg_timeout) begin
                if (collecting) framed.insert(framed.size(), TMO_WORD);
                drop_packet();
            end
        end else if (cfg_len != 0 || cfg_start != 0 || cfg_finish != 0) begin
            if (b == cfg_start) collecting = 1'b1;
            if (collecting) begin
                if (fill_cnt < MAX_LEN) begin
                    pkt_store[fill_cnt] = b;
                    fill_cnt++;
                end
                if (cfg_len != 0) begin
                    if (fill_cnt >= len_eff) begin
                        if (pkt_store[0] == cfg_start) begin
                            emit_packet();
                        end else begin
                            framed.insert(framed.size(), BAD_WORD);
                            drop_packet();
                        end
                    end
                end else if (b == cfg_finish) begin
                    emit_packet();
                end else if (fill_cnt >= MAX_LEN) begin
                    framed.insert(framed.size(), OVF_WORD);
                    drop_packet();
                end
            end
        end
    endfunction

    function void queue_word(input logic cmd, input logic [7:0] data);
        t_in_word w;
        w = '{cmd, data, 1'b0, 1'b0, NO_WORD};
        word_q.insert(word_q.size(), w);
    endfunction

    // write one register and mirror it into the predictor
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_START:   cfg_start   = val[7:0];
            REG_FINISH:  cfg_finish  = val[7:0];
            REG_LENGTH:  cfg_len     = val[5:0];
            REG_TIMEOUT: cfg_timeout = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold until every word is sent and every output word has arrived
    task automatic wait_quiet();
        while (word_q.size() != 0 || in_flight || packet_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // mostly well-formed frames with random bodies, plus ticks and noise
    task automatic queue_traffic(input int budget);
        int made, body, pick, len_eff;
        logic [7:0] b;
        made    = 0;
        len_eff = (cfg_len > MAX_LEN) ? MAX_LEN : int'(cfg_len);
        while (made < budget) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if (cfg_len != 0) body = len_eff - 1;
                else if ($urandom_range(19) == 0) body = MAX_LEN - 2 + $urandom_range(1);
                else body = $urandom_range(6);
                queue_word(CMD_BYTE, cfg_start);
                made++;
                for (int k = 0; k < body; k++) begin
                    if ($urandom_range(39) == 0) begin
                        queue_word(CMD_TICK, 8'($urandom_range(255)));
                        made++;
                    end
                    b = 8'($urandom_range(255));
                    if (cfg_len == 0 && b == cfg_finish) b = ~b;
                    queue_word(CMD_BYTE, b);
                    made++;
                end
                // leave the odd frame open
                if (cfg_len == 0 && $urandom_range(9) != 0) begin
                    queue_word(CMD_BYTE, cfg_finish);
                    made++;
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3)) begin
                    queue_word(CMD_TICK, 8'($urandom_range(255)));
                    made++;
                end
            end else begin
                queue_word(CMD_BYTE, 8'($urandom_range(255)));
                made++;
            end
        end
    endtask

    // send words; predict each one as it is accepted
    always @(posedge i_clk) begin : feed_words
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                frame_word(cur_word.cmd, cur_word.data);
                if (cur_word.typed) begin
                    if (cur_word.t_n)
                        packet_words_due.insert(packet_words_due.size(), cur_word.t_word);
                end else begin
                    foreach (framed[k])
                        packet_words_due.insert(packet_words_due.size(), framed[k]);
                end
                n_words++;
                in_flight = 1'b0;
            end
            if (!in_flight) begin
                if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_word    = word_q.pop_front();
                    in_flight   = 1'b1;
                    i_in_valid <= 1'b1;
                    i_cmd      <= cur_word.cmd;
                    i_rx_byte  <= cur_word.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // stall the output at random and check each accepted word
    always @(posedge i_clk) begin : check_words
        t_out_word got, want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_byte, o_kind, o_last};
                if (packet_words_due.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected word: byte %02h kind %0d last %0b",
                             $time, got.data, got.kind, got.last);
                end else begin
                    want = packet_words_due.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind ||
                        got.last !== want.last) begin
                        n_err++;
                        $display({"%0t: mismatch: expected byte %02h kind %0d last %0b,",
                                  " got byte %02h kind %0d last %0b"}, $time,
                                 want.data, want.kind, want.last,
                                 got.data, got.kind, got.last);
                    end
                    if (want.kind == KIND_PKT) n_pkt_bytes++;
                    else n_status++;
                end
            end
        end
    end

    initial begin : run
        t_stim_row  rw;
        t_in_word   iw;
        int         budget;
        logic [7:0] s, f;
        logic [5:0] l;
        logic [15:0] t;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < NROWS; i++) begin
            rw = DIRECTED[i];
            if (rw.op == ROW_CFG) begin
                wait_quiet();
                write_reg(rw.idx, rw.val);
            end else begin
                for (int r = 0; r < rw.reps; r++) begin
                    iw = '{rw.cmd, rw.data, rw.typed,
                           (r == rw.reps - 1) ? rw.t_n : 1'b0, rw.t_word};
                    word_q.insert(word_q.size(), iw);
                end
            end
        end

        // random traffic: two settings per idle/stall mix
        for (int ph = 0; ph < 8; ph++) begin
            wait_quiet();
            idle_pct  = IDLE_PCT[ph / 2];
            stall_pct = STALL_PCT[ph / 2];
            case (ph)
                0: begin s = 8'h00; f = 8'hFF; l = 6'd0;  t = 16'hFFFF; end
                1: begin s = 8'hFF; f = 8'h00; l = 6'd2;  t = 16'd1;    end
                2: begin s = 8'($urandom_range(255)); f = 8'($urandom_range(255));
                         l = 6'd0; t = 16'($urandom_range(4, 20)); end
                3: begin s = 8'($urandom_range(255)); f = 8'($urandom_range(255));
                         l = 6'd4; t = 16'hFFFF; end
                default: begin
                    s = 8'($urandom_range(255));
                    f = ($urandom_range(3) == 0) ? s : 8'($urandom_range(255));
                    l = ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(1, 8));
                    t = 16'($urandom_range(3, 40));
                end
            endcase
            write_reg(REG_START, {8'($urandom_range(255)), s});
            write_reg(REG_FINISH, {8'h00, f});
            write_reg(REG_LENGTH, {10'd0, l});
            write_reg(REG_TIMEOUT, t);
            budget = 3;
            queue_traffic(budget);
        end
        wait_quiet();

        $display("tb_top: %0d input words sent; %0d packet bytes and %0d status words checked",
                 n_words, n_pkt_bytes, n_status);
        $display("tb_top: directed table plus 8 random register settings, %0d failures",
                 n_err);
        if (n_err == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
